/* rtl/core/hsvrgb_pkg.sv */
// hsvrgb_pkg: word types, constants and codes for the HSV to RGB LED drive block.
// No dependencies; imported by every module in rtl/core.
package hsvrgb_pkg;

	localparam logic [7:0] FULL_SCALE = 8'd254;

	// sector boundaries on the hue circle
	localparam logic [7:0] HUE_SECT1 = 8'd43;
	localparam logic [7:0] HUE_SECT2 = 8'd85;
	localparam logic [7:0] HUE_SECT3 = 8'd128;
	localparam logic [7:0] HUE_SECT4 = 8'd170;
	localparam logic [7:0] HUE_SECT5 = 8'd212;

	// ramp origins: coef = hue - base or base - hue
	localparam logic [7:0] RAMP_BASE1 = 8'd84;
	localparam logic [7:0] RAMP_BASE2 = 8'd84;
	localparam logic [7:0] RAMP_BASE3 = 8'd169;
	localparam logic [7:0] RAMP_BASE4 = 8'd169;
	localparam logic [7:0] RAMP_BASE5 = 8'd254;

	// exact reciprocals: x/254 for x < 2^16, x/42 and x/43 for x < 11000, x/254 for x < 2^24
	localparam logic [16:0] LO_RECIP    = 17'd66053;
	localparam int          LO_SHIFT    = 24;
	localparam logic [13:0] RAMP_RECIP42 = 14'd12484;
	localparam logic [13:0] RAMP_RECIP43 = 14'd12193;
	localparam int          RAMP_SHIFT  = 19;
	localparam logic [24:0] SCALE_RECIP = 25'd16909321;
	localparam int          SCALE_SHIFT = 32;

	localparam logic [15:0] DRIVE_LIMIT     = 16'hFFFF;
	localparam logic [15:0] MAX_DRIVE_RESET = 16'd1000;

	// register map
	localparam int          PADDR_W       = 2;
	localparam logic [1:0]  REG_MAX_DRIVE = 2'd0;

	typedef enum logic [1:0] {
		SRC_LEVEL,
		SRC_LOW,
		SRC_RAMP
	} src_t;

	typedef struct packed {
		logic [7:0] hue;
		logic [7:0] saturation;
		logic [7:0] level;
		logic       lamp_on;
	} hsv_word_t;

	typedef struct packed {
		logic [15:0] red_drive;
		logic [15:0] green_drive;
		logic [15:0] blue_drive;
	} rgb_word_t;

	// channel levels between chroma and scale stages
	typedef struct packed {
		logic       off;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} chan_word_t;

endpackage

/* rtl/core/hsv_to_rgb_led_drive.sv */
// hsv_to_rgb_led_drive: top level, HSV word in, three PWM compare values out.
// Depends on hsvrgb_pkg, hsvrgb_regs, hsvrgb_chroma, hsvrgb_scale.
//
//  channel   signals                                   word
//  hsv       hsv_valid / hsv_ready / hsv               hue, saturation, level, lamp_on
//  rgb       rgb_valid / rgb_ready / rgb               red/green/blue_drive
//  apb       psel penable pwrite paddr pwdata prdata   max_drive at 0x0
//
// Six register stages, one word per cycle when rgb_ready does not stall; rgb_valid is the stage 6 valid bit.
// Stages 1-4 form the channel levels (8x8 and 16x17 for the minimum, 6x8 and 14x14 for the ramp),
// stages 5-6 scale by max_drive (three 8x16 then three 24x25 multipliers).
// Each stage holds its own valid bit; a stalled rgb side only backs up full stages.
// Reset clears valid bits and sets max_drive to 1000; no clearing pass.
module hsv_to_rgb_led_drive (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               hsv_valid,
	output logic                               hsv_ready,
	input  hsvrgb_pkg::hsv_word_t              hsv,
	output logic                               rgb_valid,
	input  logic                               rgb_ready,
	output hsvrgb_pkg::rgb_word_t              rgb,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [hsvrgb_pkg::PADDR_W-1:0]     paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import hsvrgb_pkg::*;

	logic [15:0] max_drive;
	logic        mid_valid;
	logic        mid_ready;
	chan_word_t  mid;

	hsvrgb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.max_drive (max_drive)
	);

	hsvrgb_chroma u_chroma (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hsv_valid),
		.in_ready  (hsv_ready),
		.in_word   (hsv),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out_word  (mid)
	);

	hsvrgb_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.max_drive (max_drive),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.in_word   (mid),
		.out_valid (rgb_valid),
		.out_ready (rgb_ready),
		.out_word  (rgb)
	);

`ifndef SYNTH
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr == REG_MAX_DRIVE)
		|=> (max_drive == $past(pwdata[15:0])))
		else $error("max_drive did not take the written value");

	a_scale_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!rgb_valid |-> mid_ready)
		else $error("scale stage blocked with an empty output stage");

	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!rgb_valid && !mid_valid) |-> hsv_ready)
		else $error("input blocked with empty downstream stages");
`endif

endmodule

/* rtl/core/hsvrgb_regs.sv */
// hsvrgb_regs: APB-style configuration register (max_drive).
// Depends on hsvrgb_pkg.
module hsvrgb_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [hsvrgb_pkg::PADDR_W-1:0]     paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	output logic [15:0]                        max_drive
);
	import hsvrgb_pkg::*;

	logic [15:0] max_drive_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready && (paddr == REG_MAX_DRIVE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_drive_q <= MAX_DRIVE_RESET;
		end else if (wr_en) begin
			max_drive_q <= pwdata[15:0];
		end
	end

	assign prdata    = (paddr == REG_MAX_DRIVE) ? {16'd0, max_drive_q} : 32'd0;
	assign max_drive = max_drive_q;

endmodule

/* rtl/core/hsvrgb_chroma.sv */
// hsvrgb_chroma: four-stage pipeline from hue/saturation/level to 8-bit channel levels.
// Depends on hsvrgb_pkg.
module hsvrgb_chroma (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  hsvrgb_pkg::hsv_word_t   in_word,
	output logic                    out_valid,
	input  logic                    out_ready,
	output hsvrgb_pkg::chan_word_t  out_word
);
	import hsvrgb_pkg::*;

	function automatic logic [7:0] pick(input src_t s, input logic [7:0] lvl,
		input logic [7:0] lo, input logic [7:0] ramp);
		logic [7:0] v;
		unique case (s)
			SRC_LEVEL: v = lvl;
			SRC_LOW:   v = lo;
			SRC_RAMP:  v = ramp;
			default:   v = lo;
		endcase
		return v;
	endfunction

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	// stage 1
	logic [7:0]  hue_c, sat_c;
	logic [7:0]  hue_s1, lvl_s1;
	logic        off_s1;
	logic [15:0] lo_prod_s1;

	// stage 2
	logic [32:0] lo_mult;
	logic [7:0]  hue_s2, lvl_s2, lo_s2;
	logic        off_s2;

	// stage 3
	logic [7:0]  delta;
	logic [7:0]  coef_w;
	logic        div43;
	src_t        sr, sg, sb;
	logic [13:0] ramp_prod_s3;
	logic        div43_s3, off_s3;
	logic [7:0]  lvl_s3, lo_s3;
	src_t        sr_s3, sg_s3, sb_s3;

	// stage 4
	logic [27:0] ramp_mult;
	logic [7:0]  ramp;
	chan_word_t  chan_s4;

	assign en4      = !v_s4 || out_ready;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	assign hue_c = (in_word.hue > FULL_SCALE) ? FULL_SCALE : in_word.hue;
	assign sat_c = (in_word.saturation > FULL_SCALE) ? FULL_SCALE : in_word.saturation;

	always_ff @(posedge clk) begin
		if (en1) begin
			hue_s1     <= hue_c;
			lvl_s1     <= in_word.level;
			off_s1     <= !in_word.lamp_on || (in_word.level == 8'd0);
			lo_prod_s1 <= {8'd0, in_word.level} * {8'd0, FULL_SCALE - sat_c};
		end
	end

	assign lo_mult = {17'd0, lo_prod_s1} * {16'd0, LO_RECIP};

	always_ff @(posedge clk) begin
		if (en2) begin
			hue_s2 <= hue_s1;
			lvl_s2 <= lvl_s1;
			off_s2 <= off_s1;
			lo_s2  <= lo_mult[LO_SHIFT+7:LO_SHIFT];
		end
	end

	assign delta = lvl_s2 - lo_s2;

	always_comb begin
		priority if (hue_s2 < HUE_SECT1) begin
			coef_w = hue_s2;
			div43  = 1'b0;
			sr = SRC_LEVEL; sg = SRC_RAMP;  sb = SRC_LOW;
		end else if (hue_s2 < HUE_SECT2) begin
			coef_w = RAMP_BASE1 - hue_s2;
			div43  = 1'b0;
			sr = SRC_RAMP;  sg = SRC_LEVEL; sb = SRC_LOW;
		end else if (hue_s2 < HUE_SECT3) begin
			coef_w = hue_s2 - RAMP_BASE2;
			div43  = 1'b1;
			sr = SRC_LOW;   sg = SRC_LEVEL; sb = SRC_RAMP;
		end else if (hue_s2 < HUE_SECT4) begin
			coef_w = RAMP_BASE3 - hue_s2;
			div43  = 1'b0;
			sr = SRC_LOW;   sg = SRC_RAMP;  sb = SRC_LEVEL;
		end else if (hue_s2 < HUE_SECT5) begin
			coef_w = hue_s2 - RAMP_BASE4;
			div43  = 1'b0;
			sr = SRC_RAMP;  sg = SRC_LOW;   sb = SRC_LEVEL;
		end else begin
			coef_w = RAMP_BASE5 - hue_s2;
			div43  = 1'b0;
			sr = SRC_LEVEL; sg = SRC_LOW;   sb = SRC_RAMP;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			ramp_prod_s3 <= {8'd0, coef_w[5:0]} * {6'd0, delta};
			div43_s3     <= div43;
			off_s3       <= off_s2;
			lvl_s3       <= lvl_s2;
			lo_s3        <= lo_s2;
			sr_s3        <= sr;
			sg_s3        <= sg;
			sb_s3        <= sb;
		end
	end

	assign ramp_mult = {14'd0, ramp_prod_s3} *
		{14'd0, (div43_s3 ? RAMP_RECIP43 : RAMP_RECIP42)};
	assign ramp = ramp_mult[RAMP_SHIFT+7:RAMP_SHIFT] + lo_s3;

	always_ff @(posedge clk) begin
		if (en4) begin
			chan_s4.off   <= off_s3;
			chan_s4.red   <= pick(sr_s3, lvl_s3, lo_s3, ramp);
			chan_s4.green <= pick(sg_s3, lvl_s3, lo_s3, ramp);
			chan_s4.blue  <= pick(sb_s3, lvl_s3, lo_s3, ramp);
		end
	end

	assign out_valid = v_s4;
	assign out_word  = chan_s4;

endmodule

/* rtl/core/hsvrgb_scale.sv */
// hsvrgb_scale: two-stage scaling of channel levels by max_drive/254 with 16-bit saturation.
// Depends on hsvrgb_pkg.
module hsvrgb_scale (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [15:0]             max_drive,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  hsvrgb_pkg::chan_word_t  in_word,
	output logic                    out_valid,
	input  logic                    out_ready,
	output hsvrgb_pkg::rgb_word_t   out_word
);
	import hsvrgb_pkg::*;

	function automatic logic [15:0] div_sat(input logic [23:0] y);
		logic [48:0] m;
		logic [16:0] q;
		m = {25'd0, y} * {24'd0, SCALE_RECIP};
		q = m[SCALE_SHIFT+16:SCALE_SHIFT];
		return q[16] ? DRIVE_LIMIT : q[15:0];
	endfunction

	logic        v_s5, v_s6;
	logic        en5, en6;
	logic        off_s5;
	logic [23:0] r_s5, g_s5, b_s5;
	rgb_word_t   rgb_s6;

	assign en6      = !v_s6 || out_ready;
	assign en5      = !v_s5 || en6;
	assign in_ready = en5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en5) v_s5 <= in_valid;
			if (en6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			off_s5 <= in_word.off;
			r_s5   <= {16'd0, in_word.red} * {8'd0, max_drive};
			g_s5   <= {16'd0, in_word.green} * {8'd0, max_drive};
			b_s5   <= {16'd0, in_word.blue} * {8'd0, max_drive};
		end
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			rgb_s6.red_drive   <= off_s5 ? 16'd0 : div_sat(r_s5);
			rgb_s6.green_drive <= off_s5 ? 16'd0 : div_sat(g_s5);
			rgb_s6.blue_drive  <= off_s5 ? 16'd0 : div_sat(b_s5);
		end
	end

	assign out_valid = v_s6;
	assign out_word  = rgb_s6;

endmodule
